@@ hdl/assert_macros.svh @@
// assertion macros shared by the observer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define VDO_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VDO_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/vdo_pkg.sv @@
// types and constants of the velocity disturbance observer
`timescale 1ns / 1ps
package vdo_pkg;

   localparam int MUL_W  = 64;
   localparam int PROD_W = 128;
   localparam int DEN_W  = 49;
   localparam int GT_W   = 48;
   localparam int CNT_W  = 7;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [DEN_W-1:0]  TWO_FX   = DEN_W'(1) << 33;
   localparam logic [PROD_W-1:0] TERM_CAP = PROD_W'(1) << 61;

   localparam logic [CNT_W-1:0] QA_STEPS = CNT_W'(31);
   localparam logic [CNT_W-1:0] QC_STEPS = CNT_W'(32);
   localparam logic [CNT_W-1:0] QE_STEPS = CNT_W'(32);
   localparam logic [CNT_W-1:0] QB_STEPS = CNT_W'(64);

   localparam logic [2:0] REG_MODE            = 3'd0;
   localparam logic [2:0] REG_CUTOFF_GAIN     = 3'd1;
   localparam logic [2:0] REG_SAMPLE_PERIOD   = 3'd2;
   localparam logic [2:0] REG_TORQUE_CONSTANT = 3'd3;
   localparam logic [2:0] REG_INERTIA         = 3'd4;

   localparam logic [31:0] RST_CUTOFF_GAIN     = 32'd6553600;
   localparam logic [31:0] RST_SAMPLE_PERIOD   = 32'd4294967;
   localparam logic [31:0] RST_TORQUE_CONSTANT = 32'd65536;
   localparam logic [31:0] RST_INERTIA         = 32'd16777;

   typedef enum logic [3:0] {
      OP_GT,
      OP_QA,
      OP_QC,
      OP_QE,
      OP_P,
      OP_QB,
      OP_TA,
      OP_TB,
      OP_TC
   } op_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] cutoff_gain;
      logic [31:0] sample_period;
      logic [31:0] torque_constant;
      logic [31:0] inertia;
   } cfg_type;

   typedef struct packed {
      logic   accept;
      logic   start_mul;
      logic   start_div;
      op_type op;
      logic   finish;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic j_zero;
      logic out_full;
   } stat_type;

endpackage

@@ hdl/vdo_csr.sv @@
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module vdo_csr
   import vdo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[CSR_ADDR_W-1:2];
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode            <= 1'b0;
         cfg_ff.cutoff_gain     <= RST_CUTOFF_GAIN;
         cfg_ff.sample_period   <= RST_SAMPLE_PERIOD;
         cfg_ff.torque_constant <= RST_TORQUE_CONSTANT;
         cfg_ff.inertia         <= RST_INERTIA;
      end else if (wr_en) begin
         case (index)
            REG_MODE:            cfg_ff.mode            <= pwdata[0];
            REG_CUTOFF_GAIN:     cfg_ff.cutoff_gain     <= pwdata;
            REG_SAMPLE_PERIOD:   cfg_ff.sample_period   <= pwdata;
            REG_TORQUE_CONSTANT: cfg_ff.torque_constant <= pwdata;
            REG_INERTIA:         cfg_ff.inertia         <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MODE:            prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.mode};
         REG_CUTOFF_GAIN:     prdata = cfg_ff.cutoff_gain;
         REG_SAMPLE_PERIOD:   prdata = cfg_ff.sample_period;
         REG_TORQUE_CONSTANT: prdata = cfg_ff.torque_constant;
         REG_INERTIA:         prdata = cfg_ff.inertia;
         default:             prdata = '0;
      endcase
   end

endmodule

@@ hdl/vdo_mul.sv @@
// 64 by 64 multiplier built from four 32 by 32 partial products
`timescale 1ns / 1ps
module vdo_mul
   import vdo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_W-1:0]  x,
   input  logic [MUL_W-1:0]  y,
   output logic              busy,
   output logic              done,
   output logic [PROD_W-1:0] prod
);

   logic [MUL_W-1:0]  x_ff;
   logic [MUL_W-1:0]  y_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] acc_in;
   logic [1:0]        step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [31:0]       x_part;
   logic [31:0]       y_part;
   logic [63:0]       pp;
   logic [PROD_W-1:0] pp_shift;

   assign x_part = step_ff[0] ? x_ff[63:32] : x_ff[31:0];
   assign y_part = step_ff[1] ? y_ff[63:32] : y_ff[31:0];
   assign pp     = x_part * y_part;

   always_comb begin
      case (step_ff)
         2'd0:    pp_shift = {64'b0, pp};
         2'd1:    pp_shift = {32'b0, pp, 32'b0};
         2'd2:    pp_shift = {32'b0, pp, 32'b0};
         2'd3:    pp_shift = {pp, 64'b0};
         default: pp_shift = '0;
      endcase
   end

   assign acc_in = acc_ff + pp_shift;
   assign busy   = busy_ff;
   assign done   = done_ff;
   assign prod   = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= x;
         y_ff   <= y;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ hdl/vdo_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module vdo_div
   import vdo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DEN_W-1:0] rem_init,
   input  logic [MUL_W-1:0] low,
   input  logic [CNT_W-1:0] count,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic             done,
   output logic [MUL_W-1:0] quot
);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [MUL_W-1:0] sh_ff;
   logic [MUL_W-1:0] sh_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             qbit;

   assign trial  = {rem_ff, sh_ff[MUL_W-1]};
   assign diff   = trial - {1'b0, den_ff};
   assign qbit   = (trial >= {1'b0, den_ff});
   assign rem_in = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   assign sh_in  = {sh_ff[MUL_W-2:0], qbit};
   assign busy   = busy_ff;
   assign done   = done_ff;
   assign quot   = sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= count;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         sh_ff  <= low;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
      end
   end

endmodule

@@ hdl/vdo_dp.sv @@
// observer datapath: sample state, coefficients, terms and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vdo_dp
   import vdo_pkg::*;
#(
   parameter int SW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  cfg_type              cfg,
   input  logic signed [SW-1:0] req_current_a,
   input  logic signed [SW-1:0] req_current_b,
   input  logic signed [SW-1:0] req_velocity_a,
   input  logic signed [SW-1:0] req_velocity_b,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic signed [SW-1:0] rsp_torque_estimate,
   output logic                 rsp_saturated
);

   localparam int SUM_W = SW + 2;
   localparam logic signed [63:0] SIG_MAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
   localparam logic signed [63:0] SIG_MIN = -SIG_MAX - 64'sd1;

   logic signed [SW-1:0]    prev_est_ff;
   logic signed [SW-1:0]    prev_ia_ff;
   logic signed [SW-1:0]    prev_ib_ff;
   logic signed [SW-1:0]    prev_va_ff;
   logic signed [SW-1:0]    prev_vb_ff;
   logic signed [SUM_W-1:0] isum_ff;
   logic signed [SUM_W-1:0] wsum_ff;
   logic signed [SUM_W-1:0] isum_in;
   logic signed [SUM_W-1:0] wsum_in;
   logic [GT_W-1:0]         gt_ff;
   logic [30:0]             qa_ff;
   logic [31:0]             qc_ff;
   logic [31:0]             qe_ff;
   logic [MUL_W-1:0]        qb_ff;
   logic [MUL_W-1:0]        p_ff;
   logic signed [63:0]      term_ff;
   logic signed [63:0]      term_in;
   logic                    term_pend_ff;
   logic signed [63:0]      sum_ff;
   logic                    out_valid_ff;
   logic signed [SW-1:0]    est_out_ff;
   logic                    sat_out_ff;

   logic signed [SUM_W-1:0] ia_x, ib_x, va_x, vb_x, pia_x, pib_x, pva_x, pvb_x;
   logic [DEN_W-1:0]        den_d;
   logic [DEN_W-1:0]        na;
   logic                    a_neg;
   logic [SW-1:0]           pe_mag;
   logic [SUM_W-1:0]        isum_mag;
   logic [SUM_W-1:0]        wsum_mag;

   logic [MUL_W-1:0]  mul_x, mul_y;
   logic              mul_busy, mul_done;
   logic [PROD_W-1:0] prod;
   logic [DEN_W-1:0]  div_rem, div_den;
   logic [MUL_W-1:0]  div_low;
   logic [CNT_W-1:0]  div_cnt;
   logic              div_busy, div_done;
   logic [MUL_W-1:0]  quot;

   logic [PROD_W-1:0] shifted;
   logic [61:0]       mag;
   logic              term_neg;
   logic              is_term;
   logic signed [SW-1:0] est_in;
   logic              sat_in;

   assign ia_x  = SUM_W'(req_current_a);
   assign ib_x  = SUM_W'(req_current_b);
   assign va_x  = SUM_W'(req_velocity_a);
   assign vb_x  = SUM_W'(req_velocity_b);
   assign pia_x = SUM_W'(prev_ia_ff);
   assign pib_x = SUM_W'(prev_ib_ff);
   assign pva_x = SUM_W'(prev_va_ff);
   assign pvb_x = SUM_W'(prev_vb_ff);

   always_comb begin
      if (cfg.mode) begin
         isum_in = ia_x + ib_x + pia_x + pib_x;
         wsum_in = pva_x + pvb_x - vb_x - va_x;
      end else begin
         isum_in = ia_x - ib_x + pia_x - pib_x;
         wsum_in = vb_x - va_x + pva_x - pvb_x;
      end
   end

   assign den_d = TWO_FX + {1'b0, gt_ff};
   assign a_neg = ({1'b0, gt_ff} > TWO_FX);
   assign na    = a_neg ? ({1'b0, gt_ff} - TWO_FX) : (TWO_FX - {1'b0, gt_ff});

   assign pe_mag   = prev_est_ff[SW-1] ? SW'(-prev_est_ff) : SW'(prev_est_ff);
   assign isum_mag = isum_ff[SUM_W-1] ? SUM_W'(-isum_ff) : SUM_W'(isum_ff);
   assign wsum_mag = wsum_ff[SUM_W-1] ? SUM_W'(-wsum_ff) : SUM_W'(wsum_ff);

   // operand selection for the shared units
   always_comb begin
      mul_x   = '0;
      mul_y   = '0;
      div_rem = '0;
      div_low = '0;
      div_cnt = QE_STEPS;
      div_den = den_d;
      case (cmd.op)
         OP_GT: begin
            mul_x = {32'b0, cfg.cutoff_gain};
            mul_y = {32'b0, cfg.sample_period};
         end
         OP_QA: begin
            div_rem = {1'b0, na[DEN_W-1:1]};
            div_low = {na[0], {(MUL_W-1){1'b0}}};
            div_cnt = QA_STEPS;
         end
         OP_QC: begin
            div_rem = {16'b0, cfg.cutoff_gain, 1'b0};
            div_cnt = QC_STEPS;
         end
         OP_QE: begin
            div_rem = {1'b0, gt_ff};
            div_cnt = QE_STEPS;
         end
         OP_P: begin
            mul_x = {32'b0, qe_ff};
            mul_y = {32'b0, cfg.torque_constant};
         end
         OP_QB: begin
            div_low = p_ff;
            div_cnt = QB_STEPS;
            div_den = {9'b0, cfg.inertia, 8'b0};
         end
         OP_TA: begin
            mul_x = {33'b0, qa_ff};
            mul_y = {{(MUL_W-SW){1'b0}}, pe_mag};
         end
         OP_TB: begin
            mul_x = qb_ff;
            mul_y = {{(MUL_W-SUM_W){1'b0}}, isum_mag};
         end
         OP_TC: begin
            mul_x = {32'b0, qc_ff};
            mul_y = {{(MUL_W-SUM_W){1'b0}}, wsum_mag};
         end
         default: ;
      endcase
   end

   vdo_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_mul),
      .x     (mul_x),
      .y     (mul_y),
      .busy  (mul_busy),
      .done  (mul_done),
      .prod  (prod)
   );

   vdo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .rem_init (div_rem),
      .low      (div_low),
      .count    (div_cnt),
      .den      (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (quot)
   );

   // scaled, capped and signed term
   always_comb begin
      shifted  = (cmd.op == OP_TA) ? (prod >> 30) : (prod >> 16);
      mag      = (shifted > TERM_CAP) ? TERM_CAP[61:0] : shifted[61:0];
      case (cmd.op)
         OP_TA:   term_neg = a_neg ^ prev_est_ff[SW-1];
         OP_TB:   term_neg = isum_ff[SUM_W-1];
         OP_TC:   term_neg = wsum_ff[SUM_W-1];
         default: term_neg = 1'b0;
      endcase
      term_in = term_neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
   end

   assign is_term = (cmd.op == OP_TA) || (cmd.op == OP_TB) || (cmd.op == OP_TC);

   // saturation of the final sum; with zero inertia the limit follows the sign of isum
   always_comb begin
      if (stat.j_zero) begin
         est_in = isum_ff[SUM_W-1] ? SW'(SIG_MIN) : SW'(SIG_MAX);
         sat_in = 1'b1;
      end else if (sum_ff > SIG_MAX) begin
         est_in = SW'(SIG_MAX);
         sat_in = 1'b1;
      end else if (sum_ff < SIG_MIN) begin
         est_in = SW'(SIG_MIN);
         sat_in = 1'b1;
      end else begin
         est_in = sum_ff[SW-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_est_ff  <= '0;
         prev_ia_ff   <= '0;
         prev_ib_ff   <= '0;
         prev_va_ff   <= '0;
         prev_vb_ff   <= '0;
         term_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         term_pend_ff <= mul_done && is_term;
         if (cmd.accept) begin
            prev_ia_ff <= req_current_a;
            prev_ib_ff <= req_current_b;
            prev_va_ff <= req_velocity_a;
            prev_vb_ff <= req_velocity_b;
         end
         if (cmd.finish) begin
            prev_est_ff  <= est_in;
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         isum_ff <= isum_in;
         wsum_ff <= wsum_in;
         sum_ff  <= '0;
      end else if (term_pend_ff) begin
         sum_ff <= sum_ff + term_ff;
      end
      if (mul_done) begin
         case (cmd.op)
            OP_GT:   gt_ff <= prod[GT_W+15:16];
            OP_P:    p_ff  <= prod[MUL_W-1:0];
            default: ;
         endcase
         term_ff <= term_in;
      end
      if (div_done) begin
         case (cmd.op)
            OP_QA:   qa_ff <= quot[30:0];
            OP_QC:   qc_ff <= quot[31:0];
            OP_QE:   qe_ff <= quot[31:0];
            OP_QB:   qb_ff <= quot;
            default: ;
         endcase
      end
      if (cmd.finish) begin
         est_out_ff <= est_in;
         sat_out_ff <= sat_in;
      end
   end

   assign stat.mul_done = mul_done;
   assign stat.div_done = div_done;
   assign stat.j_zero   = (cfg.inertia == 32'd0);
   assign stat.out_full = out_valid_ff;

   assign rsp_valid           = out_valid_ff;
   assign rsp_torque_estimate = est_out_ff;
   assign rsp_saturated       = sat_out_ff;

   `VDO_ASSERT_IMPL(a_units_exclusive, mul_busy, !div_busy, "multiplier and divider both busy")
   `VDO_ASSERT_IMPL(a_finish_idle, cmd.finish, !mul_busy && !div_busy && !term_pend_ff,
                    "result written while a unit is still working")
   `VDO_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_ff, "result not presented")

endmodule

@@ hdl/vdo_ctrl.sv @@
// sequencer that steps the datapath through one sample
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vdo_ctrl
   import vdo_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GT,
      ST_QA,
      ST_QC,
      ST_QE,
      ST_P,
      ST_QB,
      ST_TA,
      ST_TB,
      ST_TC,
      ST_ADD,
      ST_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         entry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         entry_ff <= (state_in != state_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.accept    = 1'b0;
      cmd.start_mul = 1'b0;
      cmd.start_div = 1'b0;
      cmd.op        = OP_GT;
      cmd.finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = stat.j_zero ? ST_FINAL : ST_GT;
            end
         end
         ST_GT: begin
            cmd.op        = OP_GT;
            cmd.start_mul = entry_ff;
            if (stat.mul_done) state_in = ST_QA;
         end
         ST_QA: begin
            cmd.op        = OP_QA;
            cmd.start_div = entry_ff;
            if (stat.div_done) state_in = ST_QC;
         end
         ST_QC: begin
            cmd.op        = OP_QC;
            cmd.start_div = entry_ff;
            if (stat.div_done) state_in = ST_QE;
         end
         ST_QE: begin
            cmd.op        = OP_QE;
            cmd.start_div = entry_ff;
            if (stat.div_done) state_in = ST_P;
         end
         ST_P: begin
            cmd.op        = OP_P;
            cmd.start_mul = entry_ff;
            if (stat.mul_done) state_in = ST_QB;
         end
         ST_QB: begin
            cmd.op        = OP_QB;
            cmd.start_div = entry_ff;
            if (stat.div_done) state_in = ST_TA;
         end
         ST_TA: begin
            cmd.op        = OP_TA;
            cmd.start_mul = entry_ff;
            if (stat.mul_done) state_in = ST_TB;
         end
         ST_TB: begin
            cmd.op        = OP_TB;
            cmd.start_mul = entry_ff;
            if (stat.mul_done) state_in = ST_TC;
         end
         ST_TC: begin
            cmd.op        = OP_TC;
            cmd.start_mul = entry_ff;
            if (stat.mul_done) state_in = ST_ADD;
         end
         ST_ADD: begin
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (!stat.out_full || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   `VDO_ASSERT_NEXT(a_busy_after_transfer, cmd.accept, req_stall,
                    "input taken again before the sample finished")
   `VDO_ASSERT_IMPL(a_start_single, cmd.start_mul, !cmd.start_div,
                    "both units started together")
   `VDO_ASSERT_IMPL(a_finish_in_final, cmd.finish, state_ff == ST_FINAL,
                    "result written outside the final step")

endmodule

@@ hdl/velocity_disturbance_observer.sv @@
// the result is valid once the sample from the input transfer is computed; zero inertia
// skips to a saturated result. One sample at a time: req_stall holds until the result is
// written. Computation time is set by the shared 1-bit-per-cycle divider, 159 steps for
// four quotients, plus five multiplies on the shared 32x32 partial-product multiplier
// reset (synchronous, active high) clears the observer state and restores register defaults
`timescale 1ns / 1ps
module velocity_disturbance_observer
   import vdo_pkg::*;
#(
   parameter int SIGNAL_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SIGNAL_WIDTH-1:0] req_current_a,
   input  logic signed [SIGNAL_WIDTH-1:0] req_current_b,
   input  logic signed [SIGNAL_WIDTH-1:0] req_velocity_a,
   input  logic signed [SIGNAL_WIDTH-1:0] req_velocity_b,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SIGNAL_WIDTH-1:0] rsp_torque_estimate,
   output logic                           rsp_saturated,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [CSR_ADDR_W-1:0]          paddr,
   input  logic [CSR_DATA_W-1:0]          pwdata,
   output logic [CSR_DATA_W-1:0]          prdata,
   output logic                           pready
);

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   vdo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vdo_dp #(
      .SW (SIGNAL_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .cfg                 (cfg),
      .req_current_a       (req_current_a),
      .req_current_b       (req_current_b),
      .req_velocity_a      (req_velocity_a),
      .req_velocity_b      (req_velocity_b),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_torque_estimate (rsp_torque_estimate),
      .rsp_saturated       (rsp_saturated)
   );

endmodule
